// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file fpa_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FPA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define FPA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked during reset.
`define FPA_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication in reset");

`endif

// File: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, constants and codes of the fixed-point ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;   // dividend width, quotient bits
  localparam int PR_W      = DATA_W + NUM_W;       // remainder plus dividend
  localparam int MAG_W     = 2 * DATA_W;           // unrounded magnitude width

  localparam logic [DATA_W-1:0] MAX_RAW = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_RAW = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL  = 4'd2,  CMD_DIV  = 4'd3,
    CMD_GT   = 4'd4,  CMD_LT   = 4'd5,  CMD_GE   = 4'd6,  CMD_LE   = 4'd7,
    CMD_EQ   = 4'd8,  CMD_NE   = 4'd9,  CMD_MIN  = 4'd10, CMD_MAX  = 4'd11,
    CMD_INC  = 4'd12, CMD_DEC  = 4'd13, CMD_FINT = 4'd14, CMD_TINT = 4'd15
  } fpa_cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } fpa_status_t;

  // How the back end finishes a word
  typedef enum logic [1:0] {
    K_PASS = 2'd0,
    K_MUL  = 2'd1,
    K_DIV  = 2'd2
  } fpa_kind_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_flag;
    logic [1:0]         status;
  } fpa_out_t;

  // Word travelling down the pipeline
  typedef struct packed {
    fpa_kind_t         kind;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              flag;
    fpa_status_t       status;
    logic [DATA_W-1:0] den;
    logic [PR_W-1:0]   pr;
  } fpa_item_t;

endpackage

// File: rtl/core/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU, pipelined, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_word carries an opcode and two raw
// operands; output channel out_valid / out_stall / out_word carries the raw
// result, the comparison flag and the status.
// Every operation takes the same path: decode, multiply, a row of
// NUM_W = 32 + FRAC_BITS division cells (one quotient bit each) and a
// rounding stage with the output register; words of every opcode leave
// in order.
// Throughput is one word per cycle while the receiver does not stall; the row
// of division cells sets the latency, the multiplier sets the longest path.
// When the receiver stalls, the output register holds its word and the
// pipeline keeps moving until its last stage is occupied; only then is
// in_stall raised. Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fpa_pkg::fpa_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output fpa_pkg::fpa_out_t out_word
);

  logic                 en;
  logic                 row_valid [fpa_pkg::NUM_W+1];
  fpa_pkg::fpa_item_t   row_item  [fpa_pkg::NUM_W+1];

  // Whole pipeline advances unless a finished word is blocked at the end
  assign en       = !(row_valid[fpa_pkg::NUM_W] && out_valid && out_stall);
  assign in_stall = !en;

  fpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_valid (row_valid[0]),
    .out_item  (row_item[0])
  );

  // Divider row
  for (genvar i = 0; i < fpa_pkg::NUM_W; i++) begin : g_cell
    fpa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .prev_valid (row_valid[i]),
      .prev_item  (row_item[i]),
      .cell_valid (row_valid[i+1]),
      .cell_item  (row_item[i+1])
    );
  end

  fpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (row_valid[fpa_pkg::NUM_W]),
    .last_item  (row_item[fpa_pkg::NUM_W]),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

endmodule

// File: rtl/core/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Decode and simple operations, then the magnitude multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  fpa_pkg::fpa_in_t   in_word,
  output logic               out_valid,
  output fpa_pkg::fpa_item_t out_item
);

  logic signed [31:0]         a;
  logic signed [31:0]         b;
  logic [fpa_pkg::DATA_W:0]   sum;
  logic [fpa_pkg::DATA_W-1:0] mag_a;
  logic [fpa_pkg::DATA_W-1:0] mag_b;
  logic [fpa_pkg::FRAC_BITS:0] hi;
  logic [fpa_pkg::MAG_W-1:0]  prod;
  fpa_pkg::fpa_item_t         a_nxt;
  fpa_pkg::fpa_item_t         a_r;
  fpa_pkg::fpa_item_t         b_nxt;
  fpa_pkg::fpa_item_t         b_r;
  logic                       va_r;
  logic                       vb_r;

  assign a     = in_word.operand_a;
  assign b     = in_word.operand_b;
  assign mag_a = a[31] ? (32'd0 - a) : a;
  assign mag_b = b[31] ? (32'd0 - b) : b;
  assign hi    = a[fpa_pkg::DATA_W-1 -: fpa_pkg::FRAC_BITS+1];

  // Stage A: decode, cheap ops, saturation of add-type results
  always_comb begin
    a_nxt        = '0;
    a_nxt.kind   = fpa_pkg::K_PASS;
    a_nxt.status = fpa_pkg::ST_OK;
    a_nxt.neg    = a[31] ^ b[31];
    a_nxt.den    = mag_b;
    a_nxt.pr     = fpa_pkg::PR_W'(mag_a);
    sum          = '0;
    unique case (fpa_pkg::fpa_cmd_t'(in_word.cmd))
      fpa_pkg::CMD_ADD: sum = {a[31], a} + {b[31], b};
      fpa_pkg::CMD_SUB: sum = {a[31], a} - {b[31], b};
      fpa_pkg::CMD_INC: sum = {a[31], a} + 33'd1;
      fpa_pkg::CMD_DEC: sum = {a[31], a} - 33'd1;
      default:          sum = '0;
    endcase
    unique case (fpa_pkg::fpa_cmd_t'(in_word.cmd))
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        if (sum[32] != sum[31]) begin
          a_nxt.status = fpa_pkg::ST_OVF;
          a_nxt.res    = sum[32] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
        end else begin
          a_nxt.res = sum[31:0];
        end
      end
      fpa_pkg::CMD_MUL: a_nxt.kind = fpa_pkg::K_MUL;
      fpa_pkg::CMD_DIV: begin
        if (b == 32'sd0) begin
          a_nxt.status = fpa_pkg::ST_DIV0;
        end else begin
          a_nxt.kind = fpa_pkg::K_DIV;
        end
      end
      fpa_pkg::CMD_GT:  a_nxt.flag = a > b;
      fpa_pkg::CMD_LT:  a_nxt.flag = a < b;
      fpa_pkg::CMD_GE:  a_nxt.flag = a >= b;
      fpa_pkg::CMD_LE:  a_nxt.flag = a <= b;
      fpa_pkg::CMD_EQ:  a_nxt.flag = a == b;
      fpa_pkg::CMD_NE:  a_nxt.flag = a != b;
      fpa_pkg::CMD_MIN: a_nxt.res  = (a < b) ? a : b;
      fpa_pkg::CMD_MAX: a_nxt.res  = (a > b) ? a : b;
      fpa_pkg::CMD_FINT: begin
        if ((|hi) && !(&hi)) begin
          a_nxt.status = fpa_pkg::ST_OVF;
          a_nxt.res    = a[31] ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
        end else begin
          a_nxt.res = a << fpa_pkg::FRAC_BITS;
        end
      end
      fpa_pkg::CMD_TINT: a_nxt.res = a >>> fpa_pkg::FRAC_BITS;
      default:           a_nxt.res = '0;
    endcase
  end

  // Stage B: magnitude product, or dividend aligned for the divider row
  assign prod = a_r.pr[fpa_pkg::DATA_W-1:0] * a_r.den;

  always_comb begin
    b_nxt = a_r;
    if (a_r.kind == fpa_pkg::K_MUL) begin
      b_nxt.pr = fpa_pkg::PR_W'(prod);
    end else if (a_r.kind == fpa_pkg::K_DIV) begin
      b_nxt.pr = fpa_pkg::PR_W'(a_r.pr[fpa_pkg::DATA_W-1:0]) << fpa_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_item  = b_r;

endmodule

// File: rtl/core/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               prev_valid,
  input  fpa_pkg::fpa_item_t prev_item,
  output logic               cell_valid,
  output fpa_pkg::fpa_item_t cell_item
);

  logic [fpa_pkg::DATA_W:0]   shifted;
  logic [fpa_pkg::DATA_W:0]   diff;
  logic                       ge;
  logic [fpa_pkg::DATA_W-1:0] rem_nxt;
  fpa_pkg::fpa_item_t         item_nxt;
  fpa_pkg::fpa_item_t         item_r;
  logic                       valid_r;

  // Partial remainder with the next dividend bit brought down
  assign shifted = prev_item.pr[fpa_pkg::PR_W-1:fpa_pkg::NUM_W-1];
  assign ge      = shifted >= {1'b0, prev_item.den};
  assign diff    = shifted - {1'b0, prev_item.den};
  assign rem_nxt = ge ? diff[fpa_pkg::DATA_W-1:0] : shifted[fpa_pkg::DATA_W-1:0];

  always_comb begin
    item_nxt = prev_item;
    if (prev_item.kind == fpa_pkg::K_DIV) begin
      item_nxt.pr = {rem_nxt, prev_item.pr[fpa_pkg::NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_item  = item_r;

endmodule

// File: rtl/core/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Rounding, sign and saturation of multiply and divide; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               last_valid,
  input  fpa_pkg::fpa_item_t last_item,
  input  logic               out_stall,
  output logic               out_valid,
  output fpa_pkg::fpa_out_t  out_word
);

  logic [fpa_pkg::NUM_W-1:0]  quot;
  logic [fpa_pkg::DATA_W-1:0] rem;
  logic                       rnd;
  logic [fpa_pkg::MAG_W-1:0]  m_div;
  logic [fpa_pkg::MAG_W-1:0]  m_mul;
  logic [fpa_pkg::MAG_W-1:0]  m;
  logic [fpa_pkg::MAG_W-1:0]  lim;
  fpa_pkg::fpa_out_t          word_nxt;
  fpa_pkg::fpa_out_t          word_r;
  logic                       valid_r;

  assign quot  = last_item.pr[fpa_pkg::NUM_W-1:0];
  assign rem   = last_item.pr[fpa_pkg::PR_W-1:fpa_pkg::NUM_W];
  // Half away from zero: round up when twice the remainder reaches the divisor
  assign rnd   = {rem, 1'b0} >= {1'b0, last_item.den};
  assign m_div = fpa_pkg::MAG_W'(quot) + fpa_pkg::MAG_W'(rnd);
  assign m_mul = (last_item.pr[fpa_pkg::MAG_W-1:0]
                  + (fpa_pkg::MAG_W'(1) << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
  assign m     = (last_item.kind == fpa_pkg::K_DIV) ? m_div : m_mul;
  assign lim   = last_item.neg ? (fpa_pkg::MAG_W'(1) << (fpa_pkg::DATA_W - 1))
                               : fpa_pkg::MAG_W'(fpa_pkg::MAX_RAW);

  always_comb begin
    word_nxt.result_value = last_item.res;
    word_nxt.compare_flag = last_item.flag;
    word_nxt.status       = last_item.status;
    if (last_item.kind != fpa_pkg::K_PASS) begin
      if (m > lim) begin
        word_nxt.status       = fpa_pkg::ST_OVF;
        word_nxt.result_value = last_item.neg ? fpa_pkg::MIN_RAW : fpa_pkg::MAX_RAW;
      end else begin
        word_nxt.result_value = last_item.neg ? (32'd0 - m[fpa_pkg::DATA_W-1:0])
                                              : m[fpa_pkg::DATA_W-1:0];
      end
    end
  end

  // Output register loads whenever it is empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid_r || !out_stall) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// File: rtl/core/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input fpa_pkg::fpa_out_t out_word
);

  // A stalled result word stays put
  `FPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_word))
  // Reset empties the output
  `FPA_ASSERT_NXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)
  // Status code is one of the defined ones
  `FPA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
                  out_word.status <= fpa_pkg::ST_DIV0)
  // Divide by zero gives a clean zero result
  `FPA_ASSERT_IMP(a_div0_zero, clk, rst_n,
                  out_valid && out_word.status == fpa_pkg::ST_DIV0,
                  out_word.result_value == 32'sd0 && !out_word.compare_flag)
  // A set comparison flag comes with a zero value and good status
  `FPA_ASSERT_IMP(a_flag_clean, clk, rst_n, out_valid && out_word.compare_flag,
                  out_word.result_value == 32'sd0 && out_word.status == fpa_pkg::ST_OK)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
